>>> hw/rtl/rlsu_pkg.sv
// Shared types, constants and saturation helpers for the RLS update block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package rlsu_pkg;
	localparam int MAX_DIM_DEF = 8;
	localparam int PW = 48;
	localparam int XW = 32;
	localparam int LW = 17;
	localparam int DW = 4;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] REG_FORGET = 2'd0;
	localparam logic [CFG_IW-1:0] REG_OMEGA  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_DIM    = 2'd2;

	localparam logic [PW-1:0] P_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [PW-1:0] T_LIM = 48'h0004_0000_0000;

	typedef struct packed {
		logic                 start;
		logic signed [PW:0]   a;
		logic signed [PW:0]   b;
		logic [PW-1:0]        dvs;
		logic                 use_div;
		logic                 lim_small;
	} md_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic signed [PW-1:0] q;
	} md_rsp_t;

	function automatic logic signed [PW-1:0] sat_p(input logic signed [63:0] v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF)
			return 48'sh7FFF_FFFF_FFFF;
		else if (v < 64'shFFFF_8000_0000_0000)
			return 48'sh8000_0000_0000;
		else
			return v[PW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] sat_w(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < 64'shFFFF_FFFF_8000_0000)
			return 32'sh8000_0000;
		else
			return v[XW-1:0];
	endfunction
endpackage

>>> hw/rtl/rlsu_samp_if.sv
// Input channel of the RLS update block: one regressor element or a restart.
// Depends on rlsu_pkg.
`timescale 1ns / 1ps
interface rlsu_samp_if;
	import rlsu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic signed [XW-1:0] x_elem;
	logic signed [XW-1:0] y_target;
	logic                 last_elem;

	modport source (output valid, op, x_elem, y_target, last_elem, input ready);
	modport sink (input valid, op, x_elem, y_target, last_elem, output ready);
endinterface

>>> hw/rtl/rlsu_coef_if.sv
// Output channel of the RLS update block: one coefficient per transfer.
// Depends on rlsu_pkg.
`timescale 1ns / 1ps
interface rlsu_coef_if;
	import rlsu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [2:0]           coef_index;
	logic signed [XW-1:0] coef_value;
	logic                 last_coef;

	modport source (output valid, coef_index, coef_value, last_coef, input ready);
	modport sink (input valid, coef_index, coef_value, last_coef, output ready);
endinterface

>>> hw/rtl/rlsu_muldiv.sv
// Shared multiply-divide unit: round(a*b/d) with ties away from zero, saturated.
// Four 32x32 partial products, then a shift by 16 or a 48-step restoring divide.
// Depends on rlsu_pkg.
`timescale 1ns / 1ps
module rlsu_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  rlsu_pkg::md_req_t   req,
	output rlsu_pkg::md_rsp_t   rsp
);
	import rlsu_pkg::*;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_MUL  = 3'd1;
	localparam logic [2:0] M_RND  = 3'd2;
	localparam logic [2:0] M_DIV  = 3'd3;
	localparam logic [2:0] M_FIN  = 3'd4;

	logic [2:0]      st_q;
	logic [2:0]      step_q;
	logic [5:0]      cyc_q;
	logic [PW-1:0]   ma_q, mb_q, d_q, r_q, lo_q;
	logic            neg_q, div_q, small_q;
	logic [63:0]     pp_q;
	logic [1:0]      psh_q;
	logic [95:0]     prod_q;

	logic [PW:0]     mag_a, mag_b;
	logic [31:0]     opa, opb;
	logic [1:0]      sh_code;
	logic [95:0]     pp_sh;
	logic [PW-1:0]   mlim, mlim_n, qm;
	logic [96:0]     half, num;
	logic [80:0]     qf;
	logic [PW:0]     r2;
	logic            ge;

	assign mag_a = req.a[PW] ? -req.a : req.a;
	assign mag_b = req.b[PW] ? -req.b : req.b;
	assign opa = step_q[1] ? {16'h0, ma_q[PW-1:32]} : ma_q[31:0];
	assign opb = step_q[0] ? {16'h0, mb_q[PW-1:32]} : mb_q[31:0];
	assign sh_code = (step_q == 3'd0) ? 2'd0 : (step_q == 3'd3) ? 2'd2 : 2'd1;

	always_comb begin
		case (psh_q)
			2'd0:    pp_sh = {32'h0, pp_q};
			2'd1:    pp_sh = {pp_q, 32'h0};
			2'd2:    pp_sh = {pp_q[31:0], 64'h0};
			default: pp_sh = '0;
		endcase
	end

	assign mlim   = small_q ? T_LIM : P_MAX;
	assign mlim_n = mlim + PW'(neg_q);
	assign half   = div_q ? 97'(d_q >> 1) : 97'(16'h8000);
	assign num    = {1'b0, prod_q} + half;
	assign qf     = num[96:16];
	assign r2     = {r_q, lo_q[PW-1]};
	assign ge     = r2 >= {1'b0, d_q};
	assign qm     = (lo_q > mlim_n) ? mlim_n : lo_q;

	always_comb begin
		rsp.busy = st_q != M_IDLE;
		rsp.done = st_q == M_FIN;
		rsp.q    = neg_q ? -qm : qm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			step_q <= '0;
			cyc_q  <= '0;
		end else begin
			case (st_q)
				M_IDLE: if (req.start) begin
					st_q   <= M_MUL;
					step_q <= '0;
				end
				M_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						st_q <= M_RND;
				end
				M_RND: begin
					cyc_q <= '0;
					if (div_q && num[96:48] < {1'b0, d_q})
						st_q <= M_DIV;
					else
						st_q <= M_FIN;
				end
				M_DIV: begin
					cyc_q <= cyc_q + 6'd1;
					if (cyc_q == 6'(PW - 1))
						st_q <= M_FIN;
				end
				M_FIN: st_q <= M_IDLE;
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: if (req.start) begin
				ma_q    <= mag_a[PW-1:0];
				mb_q    <= mag_b[PW-1:0];
				neg_q   <= req.a[PW] ^ req.b[PW];
				d_q     <= req.dvs;
				div_q   <= req.use_div;
				small_q <= req.lim_small;
				prod_q  <= '0;
			end
			M_MUL: begin
				if (step_q != 3'd4) begin
					pp_q  <= opa * opb;
					psh_q <= sh_code;
				end
				if (step_q != 3'd0)
					prod_q <= prod_q + pp_sh;
			end
			M_RND: begin
				if (!div_q)
					lo_q <= (qf > 81'(mlim_n)) ? mlim_n : qf[PW-1:0];
				else if (num[96:48] >= {1'b0, d_q})
					lo_q <= mlim_n;
				else begin
					r_q  <= num[95:48];
					lo_q <= num[PW-1:0];
				end
			end
			M_DIV: begin
				r_q  <= ge ? PW'(r2 - {1'b0, d_q}) : r2[PW-1:0];
				lo_q <= {lo_q[PW-2:0], ge};
			end
			default: ;
		endcase
	end
endmodule

>>> hw/rtl/recursive_least_squares_update_top.sv
// RLS update with forgetting factor: element items are taken in the idle state; the last
// element of a sample starts the update, whose pace is set by the one shared multiply-divide
// unit (48-step divider) and the single-port gain-matrix memory, and which the output can stall.
// Restart: 2^48/omega on the divider, then a sweep that writes the whole MAX_DIM*MAX_DIM memory.
// Reset runs the same restart sequence; no item is taken until it ends.
// Depends on rlsu_pkg, rlsu_samp_if, rlsu_coef_if and rlsu_muldiv.
`timescale 1ns / 1ps
module recursive_least_squares_update_top #(
	parameter int MAX_DIM = rlsu_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rlsu_samp_if.sink                     samp,
	rlsu_coef_if.source                   coef,
	input  logic                          cfg_we,
	input  logic [rlsu_pkg::CFG_IW-1:0]   cfg_idx,
	input  logic [rlsu_pkg::XW-1:0]       cfg_data
);
	import rlsu_pkg::*;

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACW   = PW + 1 + IW;
	localparam logic [IW-1:0] IMAX = IW'(MAX_DIM - 1);

	localparam logic [4:0] S_BOOT    = 5'd0;
	localparam logic [4:0] S_DIAGW   = 5'd1;
	localparam logic [4:0] S_SWEEP   = 5'd2;
	localparam logic [4:0] S_IDLE    = 5'd3;
	localparam logic [4:0] S_PX_RD   = 5'd4;
	localparam logic [4:0] S_PX_MUL  = 5'd5;
	localparam logic [4:0] S_PX_W    = 5'd6;
	localparam logic [4:0] S_G_MUL   = 5'd7;
	localparam logic [4:0] S_G_W     = 5'd8;
	localparam logic [4:0] S_GAM     = 5'd9;
	localparam logic [4:0] S_GCHK    = 5'd10;
	localparam logic [4:0] S_TX_MUL  = 5'd11;
	localparam logic [4:0] S_TX_W    = 5'd12;
	localparam logic [4:0] S_ERR     = 5'd13;
	localparam logic [4:0] S_TH_MUL  = 5'd14;
	localparam logic [4:0] S_TH_W    = 5'd15;
	localparam logic [4:0] S_PU_RD   = 5'd16;
	localparam logic [4:0] S_PU_MUL1 = 5'd17;
	localparam logic [4:0] S_PU_W1   = 5'd18;
	localparam logic [4:0] S_PU_MUL2 = 5'd19;
	localparam logic [4:0] S_PU_W2   = 5'd20;
	localparam logic [4:0] S_EMIT    = 5'd21;

	// configuration
	logic [LW-1:0]        lam_q;
	logic [XW-1:0]        omega_q;
	logic [DW-1:0]        dim_q;
	logic [LW-1:0]        lam_eff;
	logic [CW-1:0]        d_eff;

	// control
	logic [4:0]           state_q;
	logic [IW-1:0]        i_q, j_q, dm1_q;
	logic [CW-1:0]        cnt_q, n_q;
	logic                 ov_q;

	// datapath
	logic signed [XW-1:0] buf_q   [MAX_DIM];
	logic signed [PW-1:0] px_q    [MAX_DIM];
	logic signed [XW-1:0] theta_q [MAX_DIM];
	logic signed [XW-1:0] y_q, err_q;
	logic signed [ACW-1:0] acc_q;
	logic signed [PW-1:0] gamma_q, diag_q;
	logic signed [PW:0]   diff_q;
	logic [2:0]           oidx_q;
	logic signed [XW-1:0] oval_q;
	logic                 olast_q;

	// gain matrix memory
	logic signed [PW-1:0] pmem [DEPTH];
	logic signed [PW-1:0] rdata_q;
	logic [AW-1:0]        p_addr;
	logic                 p_we, p_re;
	logic signed [PW-1:0] p_wd;

	md_req_t              md_req;
	md_rsp_t              md_rsp;
	logic signed [PW-1:0] md_q;
	logic                 md_done;

	logic                 in_xfer, keep, emit_ld, gamma_pos, i_end, j_end;
	logic signed [XW-1:0] xi, xj;
	logic signed [ACW-1:0] acc_sum;

	assign lam_eff = (lam_q == '0) ? LW'(1) : lam_q;
	assign d_eff   = (dim_q == '0) ? CW'(1) :
	                 (32'(dim_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dim_q);

	assign md_q      = md_rsp.q;
	assign md_done   = md_rsp.done;
	assign in_xfer   = samp.valid && samp.ready;
	assign keep      = cnt_q < d_eff;
	assign emit_ld   = (state_q == S_EMIT) && (!ov_q || coef.ready);
	assign gamma_pos = !gamma_q[PW-1] && (gamma_q != '0);
	assign i_end     = i_q == dm1_q;
	assign j_end     = j_q == dm1_q;
	assign xi        = (CW'(i_q) < n_q) ? buf_q[i_q] : '0;
	assign xj        = (CW'(j_q) < n_q) ? buf_q[j_q] : '0;
	assign acc_sum   = acc_q + ACW'(md_q);

	assign p_addr = AW'(32'(i_q) * MAX_DIM + 32'(j_q));
	assign p_we   = (state_q == S_SWEEP) || (state_q == S_PU_W2 && md_done);
	assign p_re   = (state_q == S_PX_RD) || (state_q == S_PU_RD);
	assign p_wd   = (state_q == S_SWEEP) ? ((i_q == j_q) ? diag_q : '0) : md_q;

	assign samp.ready      = state_q == S_IDLE;
	assign coef.valid      = ov_q;
	assign coef.coef_index = oidx_q;
	assign coef.coef_value = oval_q;
	assign coef.last_coef  = olast_q;

	always_comb begin
		md_req = '0;
		case (state_q)
			S_BOOT: begin
				md_req.start   = omega_q != '0;
				md_req.a       = (PW+1)'(49'sh1_0000_0000);
				md_req.b       = (PW+1)'(49'sh1_0000);
				md_req.dvs     = PW'(omega_q);
				md_req.use_div = 1'b1;
			end
			S_PX_MUL: begin
				md_req.start = 1'b1;
				md_req.a     = (PW+1)'(rdata_q);
				md_req.b     = (PW+1)'(xj);
			end
			S_G_MUL: begin
				md_req.start = 1'b1;
				md_req.a     = (PW+1)'(xi);
				md_req.b     = (PW+1)'(px_q[i_q]);
			end
			S_TX_MUL: begin
				md_req.start = 1'b1;
				md_req.a     = (PW+1)'(theta_q[i_q]);
				md_req.b     = (PW+1)'(xi);
			end
			S_TH_MUL: begin
				md_req.start     = 1'b1;
				md_req.a         = (PW+1)'(px_q[i_q]);
				md_req.b         = (PW+1)'(err_q);
				md_req.dvs       = gamma_q;
				md_req.use_div   = 1'b1;
				md_req.lim_small = 1'b1;
			end
			S_PU_MUL1: begin
				md_req.start   = 1'b1;
				md_req.a       = (PW+1)'(px_q[i_q]);
				md_req.b       = (PW+1)'(px_q[j_q]);
				md_req.dvs     = gamma_q;
				md_req.use_div = 1'b1;
			end
			S_PU_MUL2: begin
				md_req.start   = 1'b1;
				md_req.a       = diff_q;
				md_req.b       = (PW+1)'(49'sh1_0000);
				md_req.dvs     = PW'(lam_eff);
				md_req.use_div = 1'b1;
			end
			default: ;
		endcase
	end

	rlsu_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	always_ff @(posedge clk) begin
		if (p_we)
			pmem[p_addr] <= p_wd;
		if (p_re)
			rdata_q <= pmem[p_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q   <= LW'(65536);
			omega_q <= XW'(65536);
			dim_q   <= DW'(8);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FORGET: lam_q   <= cfg_data[LW-1:0];
				REG_OMEGA:  omega_q <= cfg_data;
				REG_DIM:    dim_q   <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			i_q     <= '0;
			j_q     <= '0;
			dm1_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit_ld)
				ov_q <= 1'b1;
			else if (coef.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_BOOT: begin
					i_q     <= '0;
					j_q     <= '0;
					cnt_q   <= '0;
					state_q <= (omega_q == '0) ? S_SWEEP : S_DIAGW;
				end
				S_DIAGW: if (md_done) state_q <= S_SWEEP;
				S_SWEEP: begin
					j_q <= j_q + IW'(1);
					if (j_q == IMAX) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						if (i_q == IMAX) begin
							i_q     <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: if (in_xfer) begin
					if (samp.op)
						state_q <= S_BOOT;
					else if (samp.last_elem) begin
						n_q     <= cnt_q + CW'(keep);
						cnt_q   <= '0;
						dm1_q   <= IW'(d_eff - CW'(1));
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_PX_RD;
					end else if (keep)
						cnt_q <= cnt_q + CW'(1);
				end
				S_PX_RD:  state_q <= S_PX_MUL;
				S_PX_MUL: state_q <= S_PX_W;
				S_PX_W: if (md_done) begin
					state_q <= S_PX_RD;
					j_q     <= j_q + IW'(1);
					if (j_end) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						if (i_end) begin
							i_q     <= '0;
							state_q <= S_G_MUL;
						end
					end
				end
				S_G_MUL: state_q <= S_G_W;
				S_G_W: if (md_done) begin
					i_q     <= i_end ? '0 : i_q + IW'(1);
					state_q <= i_end ? S_GAM : S_G_MUL;
				end
				S_GAM:  state_q <= S_GCHK;
				S_GCHK: state_q <= gamma_pos ? S_TX_MUL : S_EMIT;
				S_TX_MUL: state_q <= S_TX_W;
				S_TX_W: if (md_done) begin
					i_q     <= i_end ? '0 : i_q + IW'(1);
					state_q <= i_end ? S_ERR : S_TX_MUL;
				end
				S_ERR:    state_q <= S_TH_MUL;
				S_TH_MUL: state_q <= S_TH_W;
				S_TH_W: if (md_done) begin
					i_q     <= i_end ? '0 : i_q + IW'(1);
					j_q     <= '0;
					state_q <= i_end ? S_PU_RD : S_TH_MUL;
				end
				S_PU_RD:   state_q <= S_PU_MUL1;
				S_PU_MUL1: state_q <= S_PU_W1;
				S_PU_W1:   if (md_done) state_q <= S_PU_MUL2;
				S_PU_MUL2: state_q <= S_PU_W2;
				S_PU_W2: if (md_done) begin
					state_q <= S_PU_RD;
					j_q     <= j_q + IW'(1);
					if (j_end) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						if (i_end) begin
							i_q     <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: if (emit_ld) begin
					i_q     <= i_end ? '0 : i_q + IW'(1);
					state_q <= i_end ? S_IDLE : S_EMIT;
				end
				default: state_q <= S_BOOT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_BOOT: begin
				for (int k = 0; k < MAX_DIM; k++)
					theta_q[k] <= '0;
				diag_q <= P_MAX;
			end
			S_DIAGW: if (md_done) diag_q <= md_q;
			S_IDLE: if (in_xfer && !samp.op) begin
				if (keep)
					buf_q[cnt_q[IW-1:0]] <= samp.x_elem;
				y_q   <= samp.y_target;
				acc_q <= '0;
			end
			S_PX_W: if (md_done) begin
				if (j_end) begin
					px_q[i_q] <= sat_p(64'(acc_sum));
					acc_q     <= '0;
				end else
					acc_q <= acc_sum;
			end
			S_G_W: if (md_done)
				acc_q <= i_end ? ACW'(sat_p(64'(acc_sum))) : acc_sum;
			S_GAM: begin
				gamma_q <= sat_p(64'(acc_q) + $signed(64'({lam_eff, 16'h0})));
				acc_q   <= '0;
			end
			S_TX_W: if (md_done) acc_q <= acc_sum;
			S_ERR: err_q <= sat_w(64'(y_q) - 64'(acc_q));
			S_TH_W: if (md_done)
				theta_q[i_q] <= sat_w(64'(theta_q[i_q]) + 64'(md_q));
			S_PU_W1: if (md_done)
				diff_q <= (PW+1)'(rdata_q) - (PW+1)'(md_q);
			default: ;
		endcase
		if (emit_ld) begin
			oidx_q  <= 3'(i_q);
			oval_q  <= theta_q[i_q];
			olast_q <= i_end;
		end
	end

	a_mem_wr: assert property (@(posedge clk) disable iff (!arst_n)
		p_we |-> (state_q == S_SWEEP || state_q == S_PU_W2))
		else $error("gain memory written outside sweep or update");

	a_md_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_rsp.busy)
		else $error("muldiv started while busy");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && samp.op |=> state_q == S_BOOT)
		else $error("restart transfer did not start the restart sequence");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ld && i_end |=> state_q == S_IDLE)
		else $error("emit did not end on the last coefficient");
endmodule

>>> bench/recursive_least_squares_update_top_tb.sv
// Testbench for recursive_least_squares_update_top: RLS update with forgetting and restart.
// Drives regressor elements and restarts, predicts every coefficient in fixed point.
// Depends on rlsu_pkg, rlsu_samp_if, rlsu_coef_if and recursive_least_squares_update_top.
`timescale 1ns / 1ps
module recursive_least_squares_update_top_tb;
	import rlsu_pkg::*;

	localparam int NDIM = 8;
	localparam int QUIET_LIMIT = 400000;
	localparam int SETTLE = 12000;
	localparam longint PLIM = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint WLIM = 64'sh0000_0000_7FFF_FFFF;
	localparam longint TLIM = 64'sh0000_0004_0000_0000;

	typedef struct {
		logic                 op;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic                 last;
	} elem_t;

	typedef struct {
		logic [2:0]           idx;
		logic signed [XW-1:0] value;
		logic                 last;
	} coef_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_idx = REG_FORGET;
	logic [XW-1:0] cfg_data = '0;

	rlsu_samp_if samp_bus ();
	rlsu_coef_if coef_bus ();

	recursive_least_squares_update_top dut (
		.clk(clk), .arst_n(arst_n), .samp(samp_bus.sink), .coef(coef_bus.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	elem_t pending_q[$];
	coef_t coef_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int quiet_cycles = 0;
	int n_samples = 0;
	int n_restarts = 0;
	int n_coefs = 0;

	logic [16:0] lam_reg = 17'd65536;
	logic [31:0] omega_reg = 32'd65536;
	logic [3:0] dim_reg = 4'd8;
	longint gain_m[NDIM][NDIM];
	longint theta[NDIM];
	longint xbuf[NDIM];
	longint gx[NDIM];
	int elem_cnt = 0;

	initial begin
		samp_bus.valid = 1'b0;
		samp_bus.op = 1'b0;
		samp_bus.x_elem = '0;
		samp_bus.y_target = '0;
		samp_bus.last_elem = 1'b0;
		coef_bus.ready = 1'b0;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim - 1)
			return -lim - 1;
		return v;
	endfunction

	// round(a*b/dv) with ties away from zero, clamped
	function automatic longint mul_div_round(longint a, longint b, longint dv, longint lim);
		logic neg;
		logic [127:0] ua, ub, prod, q, mlim;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		prod = ua * ub + 128'(dv >> 1);
		q = prod / 128'(dv);
		mlim = neg ? 128'(lim) + 1 : 128'(lim);
		if (q > mlim)
			q = mlim;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic void restart_estimator();
		longint diag;
		diag = (omega_reg == 0) ? PLIM
			: mul_div_round(64'sd1 << 32, 64'sd1 << 16, longint'(omega_reg), PLIM);
		for (int i = 0; i < NDIM; i++) begin
			for (int j = 0; j < NDIM; j++)
				gain_m[i][j] = (i == j) ? diag : 0;
			theta[i] = 0;
		end
		elem_cnt = 0;
	endfunction

	function automatic void ref_init();
		for (int i = 0; i < NDIM; i++) begin
			xbuf[i] = 0;
			gx[i] = 0;
		end
		restart_estimator();
	endfunction

	function automatic void rls_update(longint xv[NDIM], longint y, int d);
		longint lam, acc, gamma, err, t;
		lam = (lam_reg == 0) ? 1 : longint'(lam_reg);
		for (int i = 0; i < d; i++) begin
			acc = 0;
			for (int j = 0; j < d; j++)
				acc += mul_div_round(gain_m[i][j], xv[j], 65536, PLIM);
			gx[i] = sat(acc, PLIM);
		end
		acc = 0;
		for (int i = 0; i < d; i++)
			acc += mul_div_round(xv[i], gx[i], 65536, PLIM);
		acc = sat(acc, PLIM);
		gamma = sat(lam * 65536 + acc, PLIM);
		if (gamma <= 0)
			return;
		acc = 0;
		for (int i = 0; i < d; i++)
			acc += mul_div_round(theta[i], xv[i], 65536, PLIM);
		err = sat(y - acc, WLIM);
		for (int i = 0; i < d; i++) begin
			t = mul_div_round(gx[i], err, gamma, TLIM);
			theta[i] = sat(theta[i] + t, WLIM);
		end
		for (int i = 0; i < d; i++)
			for (int j = 0; j < d; j++) begin
				t = mul_div_round(gx[i], gx[j], gamma, PLIM);
				gain_m[i][j] = mul_div_round(gain_m[i][j] - t, 65536, lam, PLIM);
			end
	endfunction

	function automatic int active_dim();
		if (dim_reg == 0)
			return 1;
		if (dim_reg > NDIM)
			return NDIM;
		return int'(dim_reg);
	endfunction

	function automatic void predict_coefs(elem_t e);
		int d;
		longint xv[NDIM];
		coef_t c;
		d = active_dim();
		if (e.op) begin
			restart_estimator();
			n_restarts++;
			return;
		end
		if (elem_cnt < d) begin
			xbuf[elem_cnt] = longint'(e.x);
			elem_cnt++;
		end
		if (!e.last)
			return;
		for (int i = 0; i < NDIM; i++)
			xv[i] = (i < elem_cnt) ? xbuf[i] : 0;
		elem_cnt = 0;
		rls_update(xv, longint'(e.y), d);
		n_samples++;
		for (int i = 0; i < d; i++) begin
			c.idx = 3'(i);
			c.value = theta[i][31:0];
			c.last = (i == d - 1);
			coef_q.push_back(c);
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("  coef mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!samp_bus.valid || samp_bus.ready) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				samp_bus.valid <= 1'b1;
				samp_bus.op <= pending_q[0].op;
				samp_bus.x_elem <= pending_q[0].x;
				samp_bus.y_target <= pending_q[0].y;
				samp_bus.last_elem <= pending_q[0].last;
				void'(pending_q.pop_front());
			end else begin
				samp_bus.valid <= 1'b0;
			end
		end
	end

	// receiver, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			coef_bus.ready <= 1'b0;
		end else begin
			coef_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		coef_t want;
		if (arst_n) begin
			if (samp_bus.valid && samp_bus.ready)
				predict_coefs('{samp_bus.op, samp_bus.x_elem, samp_bus.y_target,
					samp_bus.last_elem});
			if (coef_bus.valid && coef_bus.ready) begin
				n_coefs++;
				if (coef_q.size() == 0) begin
					report_mismatch("unexpected transfer", coef_bus.coef_value, 0);
				end else begin
					want = coef_q.pop_front();
					if (coef_bus.coef_index !== want.idx)
						report_mismatch("index", coef_bus.coef_index, want.idx);
					if (coef_bus.coef_value !== want.value)
						report_mismatch("value", coef_bus.coef_value, want.value);
					if (coef_bus.last_coef !== want.last)
						report_mismatch("last", coef_bus.last_coef, want.last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((samp_bus.valid && samp_bus.ready) || (coef_bus.valid && coef_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [XW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORGET: lam_reg = data[16:0];
			REG_OMEGA: omega_reg = data;
			default: dim_reg = data[3:0];
		endcase
	endtask

	task automatic set_regs(logic [16:0] lam, logic [31:0] om, logic [3:0] dm);
		write_reg(REG_FORGET, XW'(lam));
		write_reg(REG_OMEGA, om);
		write_reg(REG_DIM, XW'(dm));
	endtask

	task automatic push_elem(logic op, logic [31:0] x, logic [31:0] y, logic last);
		elem_t e;
		e = '{op, x, y, last};
		pending_q.push_back(e);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || samp_bus.valid || coef_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
		endcase
	endfunction

	task automatic push_random(int budget);
		int d, n, sent;
		d = (dim_reg == 0) ? 1 : (dim_reg > NDIM ? NDIM : int'(dim_reg));
		push_elem(1'b1, $urandom, $urandom, 1'($urandom_range(1)));
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(19))
				0: n = d + $urandom_range(1, 2);
				1, 2: n = $urandom_range(1, d);
				default: n = d;
			endcase
			if ($urandom_range(29) == 0) begin
				push_elem(1'b1, $urandom, $urandom, 1'($urandom_range(1)));
				sent++;
			end
			for (int k = 0; k < n; k++)
				push_elem(1'b0, rand_word(), rand_word(), k == n - 1);
			sent += (n > d) ? d : n;
		end
	endtask

	initial begin
		logic [16:0] lam;
		logic [31:0] om;
		logic [3:0] dm;
		ref_init();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) @(posedge clk);

		// directed: extremes, short and long samples, restart mid-sample
		for (int k = 0; k < NDIM; k++)
			push_elem(1'b0, k[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h7FFF_FFFF, k == NDIM - 1);
		push_elem(1'b0, 32'h0001_0000, 32'h0, 1'b0);
		push_elem(1'b0, 32'hFFFF_0000, 32'h8000_0000, 1'b1);
		push_elem(1'b0, 32'h0002_0000, 32'h0, 1'b0);
		push_elem(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		for (int k = 0; k < NDIM + 2; k++)
			push_elem(1'b0, 32'h0000_8000 + k, 32'h0003_0000, k == NDIM + 1);
		drain();
		set_regs(17'd0, 32'd0, 4'd0);
		push_elem(1'b1, 32'h0, 32'h0, 1'b0);
		push_elem(1'b0, 32'h0001_0000, 32'h0001_0000, 1'b1);
		drain();
		set_regs(17'd1, 32'hFFFF_FFFF, 4'd15);
		push_elem(1'b1, 32'h0, 32'h0, 1'b0);
		push_elem(1'b0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1);
		drain();

		// random phases across idling modes and register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			case ($urandom_range(5))
				0: lam = 17'd65536;
				1: lam = 17'd64880;
				2: lam = 17'd1;
				3: lam = 17'd0;
				4: lam = 17'h1FFFF;
				default: lam = 17'($urandom_range(60000, 65536));
			endcase
			case ($urandom_range(4))
				0: om = 32'd65536;
				1: om = 32'd1;
				2: om = 32'd0;
				3: om = 32'hFFFF_FFFF;
				default: om = $urandom;
			endcase
			dm = (ph == 0) ? 4'd8 : (ph == 1 ? 4'd1 : 4'($urandom_range(15)));
			if (ph == 4) begin
				lam = 17'd65536;
				om = 32'd65536;
			end
			set_regs(lam, om, dm);
			if (ph == 2)
				hold_len = 20000;
			push_random(58);
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		$display("Covered %0d samples, %0d restarts, %0d coefficient transfers",
			n_samples, n_restarts, n_coefs);
		$display("over forget, omega and dimension extremes and four idling modes");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
